/* design/rrts_pkg.sv */
package rrts_pkg;

  typedef enum logic [2:0] {
    REQ_CREATE  = 3'd0,
    REQ_TICK    = 3'd1,
    REQ_BLOCK   = 3'd2,
    REQ_UNBLOCK = 3'd3,
    REQ_SLEEP   = 3'd4,
    REQ_EXIT    = 3'd5
  } req_e;

  typedef enum logic [2:0] {
    ST_UNUSED   = 3'd0,
    ST_READY    = 3'd1,
    ST_RUNNING  = 3'd2,
    ST_BLOCKED  = 3'd3,
    ST_SLEEPING = 3'd4,
    ST_EXITED   = 3'd5
  } slot_st_e;

  localparam logic [1:0] STATUS_DONE    = 2'd0;
  localparam logic [1:0] STATUS_NO_SLOT = 2'd1;
  localparam logic [1:0] STATUS_IGNORED = 2'd2;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [5:0]  task_index;
    logic [63:0] now_ms;
    logic [31:0] sleep_ms;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] cur_slot;
    logic       switched;
    logic [5:0] new_task;
    logic       ready_empty;
  } rsp_t;

  // Datapath commands
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,     // capture request
    OP_SCAN_RD,   // issue read of scan slot
    OP_SCAN_EVAL, // act on scan slot data
    OP_CHARGE,    // run_ticks[running]++
    OP_SET_CUR,   // slot_state[running] <= cmd.st, sleep writes wake
    OP_UNBLOCK,   // test and push task_index
    OP_POP_RD,    // read fifo head
    OP_SWITCH,    // apply switch
    OP_RESULT     // build response
  } op_e;

  typedef struct packed {
    op_e        op;
    slot_st_e   st;
    logic [1:0] status;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic found;
    logic queue_nonempty;
    logic cur_nonzero;
    logic unblock_ok;
  } stat_t;

endpackage

/* design/rrts_if.sv */
interface rrts_req_if;
  logic          valid;
  logic          ready;
  rrts_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* design/rrts_rsp_if.sv */
interface rrts_rsp_if;
  logic          valid;
  logic          ready;
  rrts_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* design/rrts_datapath.sv */
module rrts_datapath #(
  parameter int NUM_SLOTS = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rrts_pkg::cmd_t  cmd_i,
  input  rrts_pkg::req_t  req_i,
  output rrts_pkg::stat_t stat_o,
  output rrts_pkg::rsp_t  rsp_o
);
  localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW = IW + 1;

  // slot_state in flip-flops (needs reset), wake/ticks as memories
  rrts_pkg::slot_st_e st_q [NUM_SLOTS];
  logic [63:0] wake_mem [NUM_SLOTS];
  logic [31:0] tick_mem [NUM_SLOTS];
  logic [IW-1:0] fifo_mem [NUM_SLOTS];
  // created slots get wake/ticks cleared; valid bits stand for the all-zero reset
  logic [NUM_SLOTS-1:0] wv_q, tv_q;

  rrts_pkg::req_t req_q;
  logic [IW-1:0] run_q, before_q, scan_q, new_q, head_q, pop_q;
  logic [CW-1:0] cnt_q;
  logic          found_q;
  logic [63:0]   wrd_q;
  logic [31:0]   trd_q;
  logic          wvr_q, tvr_q;
  rrts_pkg::slot_st_e st_rd_q;
  rrts_pkg::rsp_t rsp_q;

  logic [IW-1:0] tail;
  logic [IW:0]   tsum;
  logic          full;
  logic [63:0]   wake_rd;
  logic [31:0]   tick_rd;
  logic [IW-1:0] st_ra;
  logic          create_hit;

  assign tsum = {1'b0, head_q} + cnt_q[IW:0];
  assign tail = (tsum >= (IW+1)'(NUM_SLOTS)) ? IW'(tsum - (IW+1)'(NUM_SLOTS)) : tsum[IW-1:0];
  assign full = (cnt_q >= CW'(NUM_SLOTS));
  assign wake_rd = wvr_q ? wrd_q : 64'd0;
  assign tick_rd = tvr_q ? trd_q : 32'd0;
  assign create_hit = (req_q.req_type == rrts_pkg::REQ_CREATE) && !found_q &&
                      (st_rd_q == rrts_pkg::ST_UNUSED);

  assign stat_o.scan_last      = (scan_q == IW'(NUM_SLOTS - 1));
  assign stat_o.found          = found_q;
  assign stat_o.queue_nonempty = (cnt_q != '0);
  assign stat_o.cur_nonzero    = (run_q != '0);
  assign stat_o.unblock_ok     = ({2'b0, req_q.task_index} < 8'(NUM_SLOTS)) &&
                                 (st_rd_q == rrts_pkg::ST_BLOCKED);
  assign rsp_o = rsp_q;

  // slot state read address: request index on accept, scan slot, else running slot
  always_comb begin
    case (cmd_i.op)
      rrts_pkg::OP_LATCH:   st_ra = IW'(req_i.task_index);
      rrts_pkg::OP_SCAN_RD: st_ra = scan_q;
      default:              st_ra = run_q;
    endcase
  end

  // memory read ports
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == rrts_pkg::OP_SCAN_RD) begin
      wrd_q <= wake_mem[scan_q];
      wvr_q <= wv_q[scan_q];
    end else begin
      wrd_q <= wake_mem[run_q];
      wvr_q <= wv_q[run_q];
    end
    trd_q   <= tick_mem[run_q];
    tvr_q   <= tv_q[run_q];
    pop_q   <= fifo_mem[head_q];
    st_rd_q <= st_q[st_ra];
  end

  // memory write ports
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == rrts_pkg::OP_SCAN_EVAL && create_hit) begin
      wake_mem[scan_q] <= 64'd0;
      tick_mem[scan_q] <= 32'd0;
    end else if (cmd_i.op == rrts_pkg::OP_CHARGE) begin
      tick_mem[run_q] <= tick_rd + 32'd1;
    end else if (cmd_i.op == rrts_pkg::OP_SET_CUR && req_q.req_type == rrts_pkg::REQ_SLEEP) begin
      wake_mem[run_q] <= req_q.now_ms + {32'd0, req_q.sleep_ms};
    end
  end

  // a switch pops before it pushes, so it always has room
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      rrts_pkg::OP_SCAN_EVAL: if (!full) fifo_mem[tail] <= scan_q;
      rrts_pkg::OP_UNBLOCK:   if (!full) fifo_mem[tail] <= IW'(req_q.task_index);
      rrts_pkg::OP_SWITCH:    fifo_mem[tail] <= run_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SLOTS; i++) st_q[i] <= rrts_pkg::ST_UNUSED;
      st_q[0]  <= rrts_pkg::ST_RUNNING;
      st_q[1]  <= rrts_pkg::ST_READY;
      wv_q     <= '0;
      tv_q     <= '0;
      run_q    <= '0;
      head_q   <= '0;
      cnt_q    <= '0;
      scan_q   <= '0;
      found_q  <= 1'b0;
      new_q    <= '0;
      before_q <= '0;
    end else begin
      case (cmd_i.op)
        rrts_pkg::OP_LATCH: begin
          req_q    <= req_i;
          scan_q   <= '0;
          found_q  <= 1'b0;
          new_q    <= '0;
          before_q <= run_q;
        end
        rrts_pkg::OP_SCAN_EVAL: begin
          if (req_q.req_type == rrts_pkg::REQ_CREATE) begin
            if (create_hit) begin
              found_q <= 1'b1;
              new_q   <= scan_q;
              wv_q[scan_q] <= 1'b1;
              tv_q[scan_q] <= 1'b1;
              st_q[scan_q] <= rrts_pkg::ST_READY;
              if (!full) cnt_q <= cnt_q + 1'b1;
            end
          end else if (st_rd_q == rrts_pkg::ST_SLEEPING && req_q.now_ms >= wake_rd) begin
            st_q[scan_q] <= rrts_pkg::ST_READY;
            if (!full) cnt_q <= cnt_q + 1'b1;
          end
          scan_q <= scan_q + 1'b1;
        end
        rrts_pkg::OP_CHARGE: tv_q[run_q] <= 1'b1;
        rrts_pkg::OP_SET_CUR: begin
          st_q[run_q] <= cmd_i.st;
          if (req_q.req_type == rrts_pkg::REQ_SLEEP) wv_q[run_q] <= 1'b1;
        end
        rrts_pkg::OP_UNBLOCK: begin
          st_q[IW'(req_q.task_index)] <= rrts_pkg::ST_READY;
          if (!full) cnt_q <= cnt_q + 1'b1;
        end
        rrts_pkg::OP_SWITCH: begin
          // queue known nonempty here
          head_q <= (head_q == IW'(NUM_SLOTS - 1)) ? '0 : head_q + 1'b1;
          if (pop_q != run_q) begin
            if (st_rd_q == rrts_pkg::ST_RUNNING && run_q != IW'(1)) begin
              st_q[run_q] <= rrts_pkg::ST_READY;  // count unchanged: pop and push
            end else begin
              cnt_q <= cnt_q - 1'b1;
            end
            run_q <= pop_q;
            st_q[pop_q] <= rrts_pkg::ST_RUNNING;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == rrts_pkg::OP_RESULT) begin
      rsp_q.status       <= (req_q.req_type == rrts_pkg::REQ_CREATE && !found_q) ?
                            rrts_pkg::STATUS_NO_SLOT : cmd_i.status;
      rsp_q.cur_slot     <= 6'(run_q);
      rsp_q.switched     <= (run_q != before_q);
      rsp_q.new_task     <= 6'(new_q);
      rsp_q.ready_empty  <= (cnt_q == '0);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CW'(NUM_SLOTS))
    else $error("ready count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == rrts_pkg::OP_SWITCH |-> cnt_q != '0)
    else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == rrts_pkg::OP_CHARGE |=> tv_q[$past(run_q)])
    else $error("charge lost");
endmodule

/* design/rrts_ctrl.sv */
module rrts_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            sched_enabled_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  rrts_pkg::req_t  req_i,
  input  rrts_pkg::stat_t stat_i,
  output rrts_pkg::cmd_t  cmd_o,
  output logic            out_valid_o,
  input  logic            out_ready_i
);
  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_SCAN_RD, S_SCAN_EV, S_CHG_RD, S_CHARGE,
    S_PRE_SW, S_POP_RD, S_SWITCH, S_RESULT, S_OUT
  } state_e;

  state_e state_q, state_d;
  logic [2:0] req_q;
  logic [1:0] status_d;
  logic [1:0] status_q;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    cmd_o.op = rrts_pkg::OP_NONE;
    cmd_o.st = rrts_pkg::ST_RUNNING;
    cmd_o.status = status_q;
    case (state_q)
      S_IDLE: if (in_valid_i) begin
        cmd_o.op = rrts_pkg::OP_LATCH;
        state_d  = S_DECODE;
        status_d = rrts_pkg::STATUS_DONE;
      end
      S_DECODE: begin
        case (req_q)
          rrts_pkg::REQ_CREATE: state_d = S_SCAN_RD;
          rrts_pkg::REQ_TICK: begin
            if (sched_enabled_i) state_d = S_CHG_RD;
            else begin
              status_d = rrts_pkg::STATUS_IGNORED;
              state_d  = S_RESULT;
            end
          end
          rrts_pkg::REQ_BLOCK: begin
            cmd_o.op = rrts_pkg::OP_SET_CUR;
            cmd_o.st = rrts_pkg::ST_BLOCKED;
            state_d  = S_PRE_SW;
          end
          rrts_pkg::REQ_UNBLOCK: begin
            if (stat_i.unblock_ok) cmd_o.op = rrts_pkg::OP_UNBLOCK;
            else status_d = rrts_pkg::STATUS_IGNORED;
            state_d = S_RESULT;
          end
          rrts_pkg::REQ_SLEEP: begin
            cmd_o.op = rrts_pkg::OP_SET_CUR;
            cmd_o.st = rrts_pkg::ST_SLEEPING;
            state_d  = sched_enabled_i ? S_PRE_SW : S_RESULT;
          end
          rrts_pkg::REQ_EXIT: begin
            cmd_o.op = rrts_pkg::OP_SET_CUR;
            cmd_o.st = rrts_pkg::ST_EXITED;
            state_d  = S_PRE_SW;
          end
          default: begin
            status_d = rrts_pkg::STATUS_IGNORED;
            state_d  = S_RESULT;
          end
        endcase
      end
      S_CHG_RD: state_d = S_CHARGE;
      S_CHARGE: begin
        cmd_o.op = rrts_pkg::OP_CHARGE;
        state_d  = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        cmd_o.op = rrts_pkg::OP_SCAN_RD;
        state_d  = S_SCAN_EV;
      end
      S_SCAN_EV: begin
        cmd_o.op = rrts_pkg::OP_SCAN_EVAL;
        if (stat_i.scan_last) begin
          if (req_q == rrts_pkg::REQ_CREATE) state_d = S_RESULT;
          else state_d = S_PRE_SW;
        end else state_d = S_SCAN_RD;
      end
      S_PRE_SW: begin
        if (stat_i.queue_nonempty &&
            (req_q != rrts_pkg::REQ_TICK || stat_i.cur_nonzero)) state_d = S_POP_RD;
        else state_d = S_RESULT;
      end
      S_POP_RD: state_d = S_SWITCH;
      S_SWITCH: begin
        cmd_o.op = rrts_pkg::OP_SWITCH;
        state_d  = S_RESULT;
      end
      S_RESULT: begin
        cmd_o.op = rrts_pkg::OP_RESULT;
        state_d  = S_OUT;
      end
      S_OUT: if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      req_q    <= '0;
      status_q <= rrts_pkg::STATUS_DONE;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
      if (state_q == S_IDLE && in_valid_i) req_q <= req_i.req_type;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> state_q == S_DECODE)
    else $error("accept did not start decode");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RESULT |=> out_valid_o)
    else $error("result not presented");
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(in_ready_o && out_valid_o))
    else $error("overlap of transactions");
endmodule

/* design/round_robin_task_scheduler_top.sv */
// Flow, accept to result valid: unblock, ignored and disabled tick or sleep requests
//   go from decode to the result; block, exit and enabled sleep pass PRE_SW (POP_RD and
//   SWITCH on a switch). Create scans all slots; enabled ticks charge, scan, may switch.
// Throughput: one transaction at a time, the next only after the response is taken; the
//   slot scan (read, evaluate per slot; one memory read port) sets the worst case.
// Reset: asynchronous, active low; slot 0 running, slot 1 ready, queue empty,
//   scheduling disabled.
module round_robin_task_scheduler_top #(
  parameter int NUM_SLOTS = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_wdata_i,
  rrts_req_if.sink   req,
  rrts_rsp_if.source rsp
);
  logic            sched_enabled_q;
  rrts_pkg::cmd_t  cmd;
  rrts_pkg::stat_t stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sched_enabled_q <= 1'b0;
    else if (cfg_we_i) sched_enabled_q <= cfg_wdata_i;
  end

  rrts_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .sched_enabled_i (sched_enabled_q),
    .in_valid_i      (req.valid),
    .in_ready_o      (req.ready),
    .req_i           (req.data),
    .stat_i          (stat),
    .cmd_o           (cmd),
    .out_valid_o     (rsp.valid),
    .out_ready_i     (rsp.ready)
  );

  rrts_datapath #(.NUM_SLOTS(NUM_SLOTS)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i  (cmd),
    .req_i  (req.data),
    .stat_o (stat),
    .rsp_o  (rsp.data)
  );
endmodule

/* test/round_robin_task_scheduler_top_tb.sv */
module round_robin_task_scheduler_top_tb;

  localparam int SLOTS = 64;
  localparam int IDLE_SLOT = 1;
  localparam int SETTLE_CYCLES = 2 * SLOTS + 20;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int RAND_ITEMS = 850;

  class sched_scoreboard;
    rrts_pkg::slot_st_e slot_st[SLOTS];
    logic [63:0] wake_at[SLOTS];
    logic [31:0] ticks[SLOTS];
    int          queue_slot[SLOTS];
    int          q_head, q_cnt, running, enabled;
    rrts_pkg::rsp_t expected_rsp[$];
    int          errors, checked;

    function new();
      foreach (slot_st[i]) begin
        slot_st[i] = rrts_pkg::ST_UNUSED;
        wake_at[i] = '0;
        ticks[i] = '0;
        queue_slot[i] = 0;
      end
      slot_st[0] = rrts_pkg::ST_RUNNING;
      slot_st[IDLE_SLOT] = rrts_pkg::ST_READY;
      q_head = 0;
      q_cnt = 0;
      running = 0;
      enabled = 0;
      errors = 0;
      checked = 0;
    endfunction

    function void enqueue(int s);
      slot_st[s] = rrts_pkg::ST_READY;
      if (q_cnt >= SLOTS) return;
      queue_slot[(q_head + q_cnt) % SLOTS] = s;
      q_cnt++;
    endfunction

    function void dispatch();
      int nxt, prev;
      prev = running;
      if (q_cnt == 0) return;
      nxt = queue_slot[q_head];
      q_head = (q_head + 1) % SLOTS;
      q_cnt--;
      if (nxt == prev) return;
      if (slot_st[prev] == rrts_pkg::ST_RUNNING && prev != IDLE_SLOT) enqueue(prev);
      running = nxt;
      slot_st[nxt] = rrts_pkg::ST_RUNNING;
    endfunction

    function int pick_blocked();
      int cand[$];
      foreach (slot_st[i]) if (slot_st[i] == rrts_pkg::ST_BLOCKED) cand.push_back(i);
      if (cand.size() == 0) return $urandom_range(0, SLOTS - 1);
      return cand[$urandom_range(0, cand.size() - 1)];
    endfunction

    function void note(rrts_pkg::req_t r);
      rrts_pkg::rsp_t e;
      int prior;
      prior = running;
      e = '0;
      e.status = rrts_pkg::STATUS_DONE;
      case (r.req_type)
        rrts_pkg::REQ_CREATE: begin
          e.status = rrts_pkg::STATUS_NO_SLOT;
          for (int i = 0; i < SLOTS; i++) begin
            if (slot_st[i] == rrts_pkg::ST_UNUSED) begin
              ticks[i] = '0;
              wake_at[i] = '0;
              enqueue(i);
              e.new_task = 6'(i);
              e.status = rrts_pkg::STATUS_DONE;
              break;
            end
          end
        end
        rrts_pkg::REQ_TICK: begin
          if (!enabled) e.status = rrts_pkg::STATUS_IGNORED;
          else begin
            ticks[running] = ticks[running] + 32'd1;
            for (int i = 0; i < SLOTS; i++)
              if (slot_st[i] == rrts_pkg::ST_SLEEPING && r.now_ms >= wake_at[i]) enqueue(i);
            if (q_cnt > 0 && running != 0) dispatch();
          end
        end
        rrts_pkg::REQ_BLOCK: begin
          slot_st[running] = rrts_pkg::ST_BLOCKED;
          dispatch();
        end
        rrts_pkg::REQ_UNBLOCK: begin
          if (slot_st[r.task_index] != rrts_pkg::ST_BLOCKED)
            e.status = rrts_pkg::STATUS_IGNORED;
          else enqueue(r.task_index);
        end
        rrts_pkg::REQ_SLEEP: begin
          wake_at[running] = r.now_ms + {32'd0, r.sleep_ms};
          slot_st[running] = rrts_pkg::ST_SLEEPING;
          if (enabled) dispatch();
        end
        rrts_pkg::REQ_EXIT: begin
          slot_st[running] = rrts_pkg::ST_EXITED;
          dispatch();
        end
        default: e.status = rrts_pkg::STATUS_IGNORED;
      endcase
      e.cur_slot = 6'(running);
      e.switched = (running != prior);
      e.ready_empty = (q_cnt == 0);
      expected_rsp.push_back(e);
    endfunction

    function void check(rrts_pkg::rsp_t a);
      rrts_pkg::rsp_t e;
      checked++;
      if (expected_rsp.size() == 0) begin
        $display("%0t: unexpected response %h", $time, a);
        errors++;
        return;
      end
      e = expected_rsp.pop_front();
      if (a.status !== e.status) begin
        $display("%0t: status exp %0d got %0d", $time, e.status, a.status);
        errors++;
      end
      if (a.cur_slot !== e.cur_slot) begin
        $display("%0t: cur_slot exp %0d got %0d", $time, e.cur_slot, a.cur_slot);
        errors++;
      end
      if (a.switched !== e.switched) begin
        $display("%0t: switched exp %0d got %0d", $time, e.switched, a.switched);
        errors++;
      end
      if (a.new_task !== e.new_task) begin
        $display("%0t: new_task exp %0d got %0d", $time, e.new_task, a.new_task);
        errors++;
      end
      if (a.ready_empty !== e.ready_empty) begin
        $display("%0t: ready_empty exp %0d got %0d", $time, e.ready_empty, a.ready_empty);
        errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni, cfg_we_i, cfg_wdata_i;
  rrts_req_if req ();
  rrts_rsp_if rsp ();

  round_robin_task_scheduler_top #(.NUM_SLOTS(SLOTS)) DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .req(req), .rsp(rsp)
  );

  sched_scoreboard sb;
  int  cycles = 0;
  int  sent = 0;
  bit  quiet = 0;
  bit  hold_rsp = 0;
  int  stall_left = 0;
  logic [63:0] uptime = 64'd0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL round_robin_task_scheduler_top");
      $finish;
    end
  end

  // response side: random back-pressure plus one long hold-off
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp.valid && rsp.ready) sb.check(rsp.data);
      if (hold_rsp) rsp.ready <= 1'b0;
      else if (stall_left > 0) begin
        stall_left--;
        rsp.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 15) - 1;
        rsp.ready <= 1'b0;
      end else rsp.ready <= 1'b1;
    end
  end

  initial begin
    wait (sent >= 300);
    hold_rsp = 1;
    repeat (600) @(posedge clk_i);
    hold_rsp = 0;
  end

  task automatic send_req(input rrts_pkg::req_t r);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    req.valid <= 1'b1;
    req.data <= r;
    do @(posedge clk_i); while (!req.ready);
    sb.note(r);
    sent++;
  endtask

  task automatic send_op(input logic [2:0] op, input logic [5:0] idx,
                         input logic [63:0] now, input logic [31:0] ms);
    rrts_pkg::req_t r;
    r.req_type = op;
    r.task_index = idx;
    r.now_ms = now;
    r.sleep_ms = ms;
    send_req(r);
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    while (sb.expected_rsp.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_enabled(input bit v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.enabled = v;
  endtask

  task automatic random_req();
    int w;
    logic [2:0] op;
    logic [5:0] idx;
    logic [63:0] now;
    logic [31:0] ms;
    w = $urandom_range(0, 99);
    idx = $urandom;
    if ($urandom_range(0, 19) == 0) now = {$urandom, $urandom};
    else begin
      uptime = uptime + $urandom_range(0, 40);
      now = uptime;
    end
    ms = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 60);
    if (w < 14) op = rrts_pkg::REQ_CREATE;
    else if (w < 50) op = rrts_pkg::REQ_TICK;
    else if (w < 60) op = rrts_pkg::REQ_BLOCK;
    else if (w < 75) begin
      op = rrts_pkg::REQ_UNBLOCK;
      if ($urandom_range(0, 3) != 0) idx = sb.pick_blocked();
    end else if (w < 88) op = rrts_pkg::REQ_SLEEP;
    else if (w < 94) op = rrts_pkg::REQ_EXIT;
    else if (w < 97) op = $urandom_range(6, 7);
    else op = $urandom_range(0, 5);
    send_op(op, idx, now, ms);
  endtask

  initial begin
    sb = new();
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = 1'b0;
    req.valid = 1'b0;
    req.data = '0;
    rsp.ready = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // scheduling disabled
    send_op(rrts_pkg::REQ_TICK, 0, 64'd5, 0);
    send_op(rrts_pkg::REQ_CREATE, 0, 0, 0);
    send_op(rrts_pkg::REQ_CREATE, 0, 0, 0);
    send_op(rrts_pkg::REQ_UNBLOCK, 6'd63, 0, 0);
    send_op(rrts_pkg::REQ_UNBLOCK, 6'd2, 0, 0);
    send_op(3'd6, 6'h3f, '1, '1);
    send_op(3'd7, 0, 0, 0);
    send_op(rrts_pkg::REQ_SLEEP, 0, 64'd10, 32'd5);
    send_op(rrts_pkg::REQ_BLOCK, 0, 0, 0);
    send_op(rrts_pkg::REQ_UNBLOCK, 6'd2, 0, 0);
    send_op(rrts_pkg::REQ_EXIT, 0, 0, 0);
    send_op(rrts_pkg::REQ_BLOCK, 0, 0, 0);
    set_enabled(1'b1);
    send_op(rrts_pkg::REQ_CREATE, 0, 0, 0);
    send_op(rrts_pkg::REQ_TICK, 0, '1, 0);
    send_op(rrts_pkg::REQ_SLEEP, 0, '1, '1);
    send_op(rrts_pkg::REQ_TICK, 0, 64'd0, 0);
    send_op(rrts_pkg::REQ_SLEEP, 0, 64'd100, 32'd0);
    send_op(rrts_pkg::REQ_TICK, 0, 64'd100, 0);
    send_op(rrts_pkg::REQ_EXIT, 0, 0, 0);
    send_op(rrts_pkg::REQ_TICK, 0, '1, 0);
    send_op(rrts_pkg::REQ_BLOCK, 0, 0, 0);

    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i == 350) set_enabled(1'b0);
      if (i == 500) set_enabled(1'b1);
      if (i == 720) quiet = 1;
      random_req();
    end
    drain();

    $display("Covered %0d requests and %0d responses over %0d cycles, with scheduling",
             sent, sb.checked, cycles);
    $display("toggled off and on, a long response hold-off and random idle bursts.");
    if (sb.errors == 0 && sb.expected_rsp.size() == 0)
      $display("PASS round_robin_task_scheduler_top");
    else
      $display("FAIL round_robin_task_scheduler_top");
    $finish;
  end
endmodule

/* sim.f */
design/rrts_pkg.sv
design/rrts_if.sv
design/rrts_rsp_if.sv
design/rrts_datapath.sv
design/rrts_ctrl.sv
design/round_robin_task_scheduler_top.sv
test/round_robin_task_scheduler_top_tb.sv
